### design/tick_timekeeper_assert.svh
// Assertion macros used by the tick timekeeper checker.
`ifndef TICK_TIMEKEEPER_ASSERT_SVH
`define TICK_TIMEKEEPER_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define TT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define TT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tt_pkg.sv
// Shared widths, constants, codes and control structs of the tick timekeeper.
`timescale 1ns / 1ps

package tt_pkg;

	// Field widths.
	localparam int RATE_W   = 21;
	localparam int RELOAD_W = 16;
	localparam int CNT_W    = 32;
	localparam int NS_W     = 52;
	localparam int DIV_W    = 22;
	localparam int STEP_W   = 5;
	localparam int NSMUL_W  = 20;

	// Timer constants.
	localparam logic [DIV_W-1:0]    INPUT_CLOCK   = 22'd3579545;
	localparam logic [RATE_W-1:0]   RATE_MIN      = 21'd18;
	localparam logic [RATE_W-1:0]   RATE_MAX      = 21'd1193181;
	localparam logic [RATE_W-1:0]   RATE_RESET    = 21'd1000;
	localparam logic [RELOAD_W-1:0] RELOAD_SLOW   = 16'hFFFF;
	localparam logic [RELOAD_W-1:0] RELOAD_FAST   = 16'd1;
	localparam logic [31:0]         MS_STEP       = 32'hDBB3A062;
	localparam logic [NSMUL_W-1:0]  NS_PER_MS     = 20'd1000000;

	// Reciprocal of three: (x * RECIP3) >> 25 is floor(x / 3) for any x below 2^22.
	localparam logic [23:0]         RECIP3        = 24'hAAAAAB;

	// Number of quotient bits the divider produces, one per cycle.
	localparam logic [STEP_W-1:0]   DIV_STEPS     = 5'd22;

	// Divisor selection for the shared divider.
	typedef logic div_sel_t;
	localparam div_sel_t DSEL_CLK_RATE   = 1'b0;
	localparam div_sel_t DSEL_CLK_RELOAD = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     cfg_load;
		logic     div_start;
		div_sel_t div_sel;
		logic     quo_load;
		logic     clamp_load;
		logic     reload_load;
		logic     step_load;
		logic     rate_load;
		logic     acc_en;
		logic     mul_en;
		logic     out_load;
	} tt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rate_low;
		logic rate_high;
		logic div_done;
	} tt_stat_t;

endpackage

### design/tick_timekeeper.sv
// Top level of the tick timekeeper: controller plus datapath.
// A tick transaction with the tick bit set runs through the accumulate, multiply and
// output states, waiting in output for a free result register; no new tick is taken
// until it ends. A rate write keeps the block busy deriving over two divisions (one when clamped).
// Reset (arst_n low) clears time and count and loads the rate 1000; the same
// derivation then runs, and no tick is accepted until it ends.
`timescale 1ns / 1ps

module tick_timekeeper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tt_pkg::RATE_W-1:0]     desired_rate_hz,
	input  logic                          tick_valid,
	output logic                          tick_ready,
	input  logic                          tick,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tt_pkg::NS_W-1:0]       elapsed_ns,
	output logic [tt_pkg::CNT_W-1:0]      elapsed_ms,
	output logic [tt_pkg::CNT_W-1:0]      tick_total,
	output logic [tt_pkg::RATE_W-1:0]     tick_rate_hz,
	output logic [tt_pkg::RELOAD_W-1:0]   reload_value
);

	tt_pkg::tt_cmd_t  cmd;
	tt_pkg::tt_stat_t stat;

	// Sequencing of derivation and tick transactions.
	tt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	// Arithmetic and storage.
	tt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.desired_rate_hz (desired_rate_hz),
		.elapsed_ns      (elapsed_ns),
		.elapsed_ms      (elapsed_ms),
		.tick_total      (tick_total),
		.tick_rate_hz    (tick_rate_hz),
		.reload_value    (reload_value)
	);

endmodule

### design/tt_div.sv
// Restoring divider, one quotient bit per cycle, with round-half-up result.
`timescale 1ns / 1ps

module tt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tt_pkg::DIV_W-1:0]    dividend,
	input  logic [tt_pkg::RATE_W-1:0]   divisor,
	output logic                        done,
	output logic [tt_pkg::DIV_W-1:0]    quotient
);

	logic [tt_pkg::STEP_W-1:0] cnt_q;
	logic                      done_q;
	logic [tt_pkg::DIV_W-1:0]  quo_q;
	logic [tt_pkg::RATE_W-1:0] rem_q;
	logic [tt_pkg::RATE_W-1:0] dsr_q;

	logic [tt_pkg::DIV_W-1:0]  trial;
	logic [tt_pkg::DIV_W-1:0]  diff;
	logic                      fits;
	logic [tt_pkg::RATE_W-1:0] rem_next;
	logic                      round_up;

	// One restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		trial    = {rem_q, quo_q[tt_pkg::DIV_W-1]};
		fits     = trial >= {1'b0, dsr_q};
		diff     = trial - {1'b0, dsr_q};
		rem_next = fits ? diff[tt_pkg::RATE_W-1:0] : trial[tt_pkg::RATE_W-1:0];
	end

	// Round half up: add one when twice the remainder reaches the divisor.
	always_comb begin
		round_up = {rem_q, 1'b0} >= {1'b0, dsr_q};
		quotient = quo_q + {{(tt_pkg::DIV_W-1){1'b0}}, round_up};
	end

	assign done = done_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == tt_pkg::STEP_W'(1));
			if (start) begin
				cnt_q <= tt_pkg::DIV_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - tt_pkg::STEP_W'(1);
			end
		end
	end

	// Quotient, remainder and divisor registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[tt_pkg::DIV_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

endmodule

### design/tt_dp.sv
// Datapath: rate register, derived timer values, time accumulator and result register.
`timescale 1ns / 1ps

module tt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tt_pkg::tt_cmd_t               cmd,
	output tt_pkg::tt_stat_t              stat,
	input  logic [tt_pkg::RATE_W-1:0]     desired_rate_hz,
	output logic [tt_pkg::NS_W-1:0]       elapsed_ns,
	output logic [tt_pkg::CNT_W-1:0]      elapsed_ms,
	output logic [tt_pkg::CNT_W-1:0]      tick_total,
	output logic [tt_pkg::RATE_W-1:0]     tick_rate_hz,
	output logic [tt_pkg::RELOAD_W-1:0]   reload_value
);

	// Configuration and derived values.
	logic [tt_pkg::RATE_W-1:0]   rate_q;
	logic [tt_pkg::RELOAD_W-1:0] reload_q;
	logic [tt_pkg::RATE_W-1:0]   rate_out_q;
	logic [15:0]                 step_whole_q;
	logic [31:0]                 step_frac_q;

	// Time state.
	logic [tt_pkg::CNT_W-1:0]    millis_whole_q;
	logic [31:0]                 millis_frac_q;
	logic [tt_pkg::CNT_W-1:0]    tick_cnt_q;

	// Conversion pipeline and result register.
	logic [tt_pkg::NS_W-1:0]     ms_ns_s1;
	logic [tt_pkg::NSMUL_W-1:0]  frac_ns_s1;
	logic [tt_pkg::NS_W-1:0]     timestamp_q;
	logic [tt_pkg::CNT_W-1:0]    elapsed_q;
	logic [tt_pkg::CNT_W-1:0]    tick_total_q;
	logic [tt_pkg::RATE_W-1:0]   tick_rate_q;
	logic [tt_pkg::RELOAD_W-1:0] reload_out_q;

	// Divider hookup.
	logic [tt_pkg::DIV_W-1:0]    div_dividend;
	logic [tt_pkg::RATE_W-1:0]   div_divisor;
	logic [tt_pkg::DIV_W-1:0]    div_quo;
	logic                        div_done;

	// Divide-by-three stage.
	logic [tt_pkg::DIV_W-1:0]    third_in_q;
	logic [45:0]                 third_prod;
	logic [tt_pkg::RATE_W-1:0]   third;

	logic [tt_pkg::RELOAD_W-1:0] reload_div;
	logic [tt_pkg::RELOAD_W-1:0] reload_clamp;
	logic [47:0]                 step_prod;
	logic [32:0]                 frac_sum;
	logic [tt_pkg::NS_W-1:0]     ms_prod;
	logic [tt_pkg::NS_W-1:0]     frac_prod;

	tt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Divider operands: the input clock over the rate or over the reload.
	always_comb begin
		div_dividend = tt_pkg::INPUT_CLOCK;
		unique case (cmd.div_sel)
			tt_pkg::DSEL_CLK_RATE: begin
				div_divisor = rate_q;
			end
			tt_pkg::DSEL_CLK_RELOAD: begin
				div_divisor = {{(tt_pkg::RATE_W-tt_pkg::RELOAD_W){1'b0}}, reload_q};
			end
		endcase
	end

	// Status for the controller.
	always_comb begin
		stat.rate_low  = rate_q <= tt_pkg::RATE_MIN;
		stat.rate_high = rate_q >= tt_pkg::RATE_MAX;
		stat.div_done  = div_done;
	end

	// Round-half-up divide by three of the registered quotient: floor((q + 1) / 3).
	always_comb begin
		third_prod = {24'd0, third_in_q} * {22'd0, tt_pkg::RECIP3};
		third      = third_prod[45:25];
	end

	// Reload candidates: the rounded quotient (zero forced to one) or a clamp value.
	always_comb begin
		reload_div   = (third[tt_pkg::RELOAD_W-1:0] == '0) ? tt_pkg::RELOAD_FAST
			: third[tt_pkg::RELOAD_W-1:0];
		reload_clamp = stat.rate_low ? tt_pkg::RELOAD_SLOW : tt_pkg::RELOAD_FAST;
	end

	// Tick length in 16.32 milliseconds, the 32.32 accumulator sum and the ns products.
	always_comb begin
		step_prod = {32'd0, reload_q} * {16'd0, tt_pkg::MS_STEP};
		frac_sum  = {1'b0, millis_frac_q} + {1'b0, step_frac_q};
		ms_prod   = {20'd0, millis_whole_q} * {32'd0, tt_pkg::NS_PER_MS};
		frac_prod = {20'd0, millis_frac_q} * {32'd0, tt_pkg::NS_PER_MS};
	end

	// Requested rate; reset to the default rate so the first derivation uses it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= tt_pkg::RATE_RESET;
		end else if (cmd.cfg_load) begin
			rate_q <= desired_rate_hz;
		end
	end

	// Derived reload, frequency and step.
	always_ff @(posedge clk) begin
		if (cmd.quo_load) begin
			third_in_q <= div_quo + tt_pkg::DIV_W'(1);
		end
		if (cmd.clamp_load) begin
			reload_q <= reload_clamp;
		end else if (cmd.reload_load) begin
			reload_q <= reload_div;
		end
		if (cmd.rate_load) begin
			rate_out_q <= third;
		end
		if (cmd.step_load) begin
			step_whole_q <= {10'd0, step_prod[47:42]};
			step_frac_q  <= step_prod[41:10];
		end
	end

	// Millisecond accumulator with carry and tick count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			millis_whole_q <= '0;
			millis_frac_q  <= '0;
			tick_cnt_q     <= '0;
		end else if (cmd.acc_en) begin
			millis_frac_q  <= frac_sum[31:0];
			millis_whole_q <= millis_whole_q + {16'd0, step_whole_q}
				+ {31'd0, frac_sum[32]};
			tick_cnt_q     <= tick_cnt_q + 32'd1;
		end
	end

	// Nanosecond products, then the result register.
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			ms_ns_s1   <= ms_prod;
			frac_ns_s1 <= frac_prod[51:32];
		end
		if (cmd.out_load) begin
			timestamp_q  <= ms_ns_s1 + {32'd0, frac_ns_s1};
			elapsed_q    <= millis_whole_q;
			tick_total_q <= tick_cnt_q;
			tick_rate_q  <= rate_out_q;
			reload_out_q <= reload_q;
		end
	end

	assign elapsed_ns   = timestamp_q;
	assign elapsed_ms   = elapsed_q;
	assign tick_total   = tick_total_q;
	assign tick_rate_hz = tick_rate_q;
	assign reload_value = reload_out_q;

endmodule

### design/tt_ctrl.sv
// Controller: sequences rate derivation, tick accumulation and result hand-off.
`timescale 1ns / 1ps

module tt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              tick_valid,
	output logic              tick_ready,
	input  logic              tick,
	output logic              out_valid,
	input  logic              out_ready,
	output tt_pkg::tt_cmd_t   cmd,
	input  tt_pkg::tt_stat_t  stat
);

	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_CLAMP      = 4'd1;
	localparam logic [3:0] ST_DIV_RATE   = 4'd2;
	localparam logic [3:0] ST_RELOAD     = 4'd3;
	localparam logic [3:0] ST_START_FREQ = 4'd4;
	localparam logic [3:0] ST_DIV_FREQ   = 4'd5;
	localparam logic [3:0] ST_FREQ       = 4'd6;
	localparam logic [3:0] ST_ACC        = 4'd7;
	localparam logic [3:0] ST_MUL        = 4'd8;
	localparam logic [3:0] ST_OUT        = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// A configuration write wins over a tick transaction in the idle state.
	assign cfg_ready  = state_q == ST_IDLE;
	assign tick_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign out_valid  = out_valid_q;
	assign out_free   = !out_valid_q || out_ready;

	// Next state and datapath commands.
	always_comb begin
		cmd         = '0;
		cmd.div_sel = tt_pkg::DSEL_CLK_RATE;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_valid) begin
					cmd.cfg_load = 1'b1;
					state_d      = ST_CLAMP;
				end else if (tick_valid && tick) begin
					state_d = ST_ACC;
				end
			end
			ST_CLAMP: begin
				if (stat.rate_low || stat.rate_high) begin
					cmd.clamp_load = 1'b1;
					state_d        = ST_START_FREQ;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = tt_pkg::DSEL_CLK_RATE;
					state_d       = ST_DIV_RATE;
				end
			end
			ST_DIV_RATE: begin
				if (stat.div_done) begin
					cmd.quo_load = 1'b1;
					state_d      = ST_RELOAD;
				end
			end
			ST_RELOAD: begin
				cmd.reload_load = 1'b1;
				state_d         = ST_START_FREQ;
			end
			ST_START_FREQ: begin
				cmd.step_load = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = tt_pkg::DSEL_CLK_RELOAD;
				state_d       = ST_DIV_FREQ;
			end
			ST_DIV_FREQ: begin
				if (stat.div_done) begin
					cmd.quo_load = 1'b1;
					state_d      = ST_FREQ;
				end
			end
			ST_FREQ: begin
				cmd.rate_load = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts a derivation from the default rate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLAMP;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### design/tt_checker.sv
// Port-level checker for the tick timekeeper, bound to the top level.
`timescale 1ns / 1ps
`include "tick_timekeeper_assert.svh"

module tt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          tick_valid,
	input logic                          tick_ready,
	input logic                          tick,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [tt_pkg::NS_W-1:0]       elapsed_ns,
	input logic [tt_pkg::RELOAD_W-1:0]   reload_value,
	input logic [tt_pkg::RATE_W-1:0]     tick_rate_hz
);

	// A stalled result keeps its timestamp.
	`TT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(elapsed_ns), "result changed while stalled")

	// The fastest reload always reports the fastest corrected frequency.
	`TT_ASSERT_SAME(a_fast_pair, out_valid && (reload_value == 16'd1),
		tick_rate_hz == 21'd1193182, "reload one with wrong frequency")

	// After a rate write the block is busy deriving and takes no tick.
	`TT_ASSERT_NEXT(a_cfg_busy, cfg_valid && cfg_ready,
		!tick_ready && !cfg_ready, "ready right after a rate write")

	// A tick with the bit set occupies the block for the next cycle.
	`TT_ASSERT_NEXT(a_tick_busy, tick_valid && tick_ready && tick,
		!tick_ready, "ready right after a tick")

endmodule

bind tick_timekeeper tt_checker u_tt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.tick_valid   (tick_valid),
	.tick_ready   (tick_ready),
	.tick         (tick),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.elapsed_ns   (elapsed_ns),
	.reload_value (reload_value),
	.tick_rate_hz (tick_rate_hz)
);
